// ===== rtl/ste_pkg.sv =====
// Symbol table engine: shared types, codes and field widths.
// No dependencies; used by the interfaces and by every module but ste_ram.
`timescale 1ns / 1ps

package ste_pkg;

  localparam int OPCODE_W      = 2;
  localparam int NAME_WORD_W   = 64;
  localparam int NAME_WORDS    = 4;
  localparam int IN_CHARS      = 32;
  localparam int VALUE_W       = 16;
  localparam int TYPE_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_INDEX_W = 6;

  localparam logic [VALUE_W-1:0] CODE_BASE_RST = 16'd100;

  typedef enum logic [OPCODE_W-1:0] {
    OP_DEFINE = 2'd0,
    OP_ADD    = 2'd1,
    OP_FIND   = 2'd2,
    OP_RELOC  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_LABEL = 3'd1,
    ST_DUP       = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  localparam logic [TYPE_W-1:0] TYPE_CODE   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_DATA   = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_EXTERN = 2'd2;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_UNDER   = 8'h5F;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_UP_A    = 8'h41;
  localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;

  // Name check summary from the name front end.
  typedef struct packed {
    logic too_long;    // no terminator within the name size
    logic bad_label;   // fails label syntax (includes empty and too long)
  } name_chk_t;

endpackage

// ===== rtl/ste_if.sv =====
// Symbol table engine: request and result channel interfaces.
// Depends on ste_pkg.
`timescale 1ns / 1ps

interface ste_in_if;
  logic                             valid;
  logic                             ready;
  logic [ste_pkg::OPCODE_W-1:0]     opcode;
  logic [ste_pkg::NAME_WORD_W-1:0]  name_bytes_0;
  logic [ste_pkg::NAME_WORD_W-1:0]  name_bytes_1;
  logic [ste_pkg::NAME_WORD_W-1:0]  name_bytes_2;
  logic [ste_pkg::NAME_WORD_W-1:0]  name_bytes_3;
  logic [ste_pkg::VALUE_W-1:0]      value;
  logic [ste_pkg::TYPE_W-1:0]       symbol_type;

  modport source (
    output valid, opcode, name_bytes_0, name_bytes_1, name_bytes_2, name_bytes_3,
           value, symbol_type,
    input  ready
  );
  modport sink (
    input  valid, opcode, name_bytes_0, name_bytes_1, name_bytes_2, name_bytes_3,
           value, symbol_type,
    output ready
  );
endinterface

interface ste_out_if;
  logic                               valid;
  logic                               ready;
  ste_pkg::status_t                   status;
  logic [ste_pkg::ENTRY_INDEX_W-1:0]  entry_index;
  logic [ste_pkg::VALUE_W-1:0]        found_value;
  logic [ste_pkg::TYPE_W-1:0]         found_type;
  logic                               any_external;

  modport source (
    output valid, status, entry_index, found_value, found_type, any_external,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, found_value, found_type, any_external,
    output ready
  );
endinterface

// ===== rtl/ste_ram.sv =====
// Symbol table engine: generic simple dual-port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ste_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ste_name_prep.sv =====
// Symbol table engine: name front end (cut at terminator, label check).
// Depends on ste_pkg.
`timescale 1ns / 1ps

module ste_name_prep #(
  parameter int NAME_BYTES = 32
) (
  input  logic [ste_pkg::IN_CHARS*8-1:0]  name_in,
  input  logic                            stop_colon,
  output logic [8*(NAME_BYTES-1)-1:0]     name_out,
  output ste_pkg::name_chk_t              chk
);
  import ste_pkg::*;

  logic [IN_CHARS-1:0] keep;
  logic [IN_CHARS-1:0] char_bad;

  // keep[i]: byte i lies before the first terminator
  always_comb begin
    logic       run;
    logic [7:0] c;
    run = 1'b1;
    for (int i = 0; i < IN_CHARS; i++) begin
      c = name_in[8*i +: 8];
      if (c == CHAR_NUL || (stop_colon && c == CHAR_COLON)) begin
        run = 1'b0;
      end
      keep[i] = run;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic       alpha;
    logic       word;
    for (int i = 0; i < IN_CHARS; i++) begin
      c     = name_in[8*i +: 8];
      alpha = c inside {[CHAR_UP_A:CHAR_UP_Z], [CHAR_LOW_A:CHAR_LOW_Z]};
      word  = alpha || (c inside {[CHAR_0:CHAR_9]}) || (c == CHAR_UNDER);
      char_bad[i] = keep[i] && ((i == 0) ? !alpha : !word);
    end
  end

  always_comb begin
    for (int i = 0; i < NAME_BYTES - 1; i++) begin
      name_out[8*i +: 8] = keep[i] ? name_in[8*i +: 8] : CHAR_NUL;
    end
  end

  assign chk.too_long  = keep[NAME_BYTES-1];
  assign chk.bad_label = !keep[0] || keep[NAME_BYTES-1] || (|char_bad);

endmodule

// ===== rtl/symbol_table_engine_core.sv =====
// Symbol table engine top level: control sequencer over name and value/type RAMs.
// Depends on ste_pkg, ste_if, ste_ram, ste_name_prep.
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Word contents
// in_word   in   valid/ready   opcode, name_bytes_0..3, value, symbol_type
// out_word  out  valid/ready   status, entry_index, found_value, found_type, any_external
// cfg_*     in   cfg_we        cfg_wdata -> code_base
//
// One word at a time. Define/add/find scan the name RAM one entry per cycle and stop
// early on a hit; an empty table or an overlong name reads no entry. Relocate rewrites
// data entries one per cycle. A define that fails label syntax skips the scan.
// Reset: control only; the RAMs need no clearing since only entries below the
// count are ever read. Stalls: results sit in an output register, so the next
// word is accepted while one waits; a finished word holds until that slot frees.
module symbol_table_engine_core #(
  parameter int MAX_ENTRIES = 64,
  parameter int NAME_BYTES  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ste_pkg::VALUE_W-1:0]  cfg_wdata,
  ste_in_if.sink                       in_word,
  ste_out_if.source                    out_word
);
  import ste_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int NAME_W = 8 * (NAME_BYTES - 1);
  localparam int VT_W   = VALUE_W + TYPE_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_RELOC = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ext_r, ext_nxt;
  logic [VALUE_W-1:0] code_base_r;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;

  // current word
  op_t                op_r, op_nxt;
  logic [NAME_W-1:0]  name_r, name_nxt;
  logic               too_long_r, too_long_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [TYPE_W-1:0]  typ_r, typ_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;

  // staged result and output register
  status_t            res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [VALUE_W-1:0] res_val_r, res_val_nxt;
  logic [TYPE_W-1:0]  res_typ_r, res_typ_nxt;
  logic               res_ext_r, res_ext_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [VALUE_W-1:0] out_val_r, out_val_nxt;
  logic [TYPE_W-1:0]  out_typ_r, out_typ_nxt;
  logic               out_ext_r, out_ext_nxt;

  // name front end
  op_t                in_op;
  logic [NAME_W-1:0]  prep_name;
  name_chk_t          prep_chk;

  // memories
  logic               name_we;
  logic               vt_we;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   vt_waddr;
  logic [VT_W-1:0]    vt_wdata;
  logic [NAME_W-1:0]  name_rd;
  logic [VT_W-1:0]    vt_rd;
  logic [IDX_W+ENTRY_INDEX_W-1:0] out_idx_wide;

  assign in_op = op_t'(in_word.opcode);

  ste_name_prep #(
    .NAME_BYTES (NAME_BYTES)
  ) u_prep (
    .name_in    ({in_word.name_bytes_3, in_word.name_bytes_2,
                  in_word.name_bytes_1, in_word.name_bytes_0}),
    .stop_colon (in_op == OP_DEFINE),
    .name_out   (prep_name),
    .chk        (prep_chk)
  );

  // Names: written only on a successful add or define, at the current count.
  ste_ram #(
    .WIDTH (NAME_W),
    .DEPTH (MAX_ENTRIES)
  ) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (name_r),
    .raddr (rd_addr),
    .rdata (name_rd)
  );

  // {value, type}: written on add or define, and rewritten for data entries on relocate.
  // Relocate reads entry i+1 while writing entry i, so no two accesses to one
  // entry ever overlap and no forwarding is needed.
  ste_ram #(
    .WIDTH (VT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_vt_ram (
    .clk   (clk),
    .we    (vt_we),
    .waddr (vt_waddr),
    .wdata (vt_wdata),
    .raddr (rd_addr),
    .rdata (vt_rd)
  );

  assign in_word.ready = (state_r == S_IDLE);

  always_comb begin
    logic issue;
    logic hit;
    state_nxt      = state_r;
    count_nxt      = count_r;
    ext_nxt        = ext_r;
    scan_nxt       = scan_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = scan_r[IDX_W-1:0];
    op_nxt         = op_r;
    name_nxt       = name_r;
    too_long_nxt   = too_long_r;
    val_nxt        = val_r;
    typ_nxt        = typ_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_val_nxt    = res_val_r;
    res_typ_nxt    = res_typ_r;
    res_ext_nxt    = res_ext_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_val_nxt    = out_val_r;
    out_typ_nxt    = out_typ_r;
    out_ext_nxt    = out_ext_r;
    out_valid_nxt  = out_valid_r && !out_word.ready;
    name_we        = 1'b0;
    vt_we          = 1'b0;
    vt_waddr       = pend_idx_r;
    vt_wdata       = {VALUE_W'(vt_rd[VT_W-1:TYPE_W] + val_r), vt_rd[TYPE_W-1:0]};
    rd_addr        = scan_r[IDX_W-1:0];
    issue          = 1'b0;
    hit            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_word.valid) begin
          op_nxt       = in_op;
          name_nxt     = prep_name;
          too_long_nxt = prep_chk.too_long;
          scan_nxt     = '0;
          // define folds its type to code or data
          if (in_op == OP_DEFINE) begin
            typ_nxt = (in_word.symbol_type != TYPE_CODE) ? TYPE_DATA : TYPE_CODE;
          end else begin
            typ_nxt = in_word.symbol_type;
          end
          // relocate keeps the precomputed addend
          if (in_op == OP_RELOC) begin
            val_nxt = VALUE_W'(code_base_r + in_word.value);
          end else begin
            val_nxt = in_word.value;
          end
          res_idx_nxt = '0;
          res_val_nxt = '0;
          res_typ_nxt = TYPE_CODE;
          res_ext_nxt = ext_r;
          if (in_op == OP_DEFINE && prep_chk.bad_label) begin
            res_status_nxt = ST_BAD_LABEL;
            state_nxt      = S_DONE;
          end else if (in_op == OP_RELOC) begin
            state_nxt = S_RELOC;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // overlong names never match a stored entry
        issue = !too_long_r && (scan_r < count_r);
        hit   = pend_r && (name_rd == name_r);
        if (hit) begin
          if (op_r == OP_FIND) begin
            res_status_nxt = ST_OK;
            res_idx_nxt    = pend_idx_r;
            res_val_nxt    = vt_rd[VT_W-1:TYPE_W];
            res_typ_nxt    = vt_rd[TYPE_W-1:0];
          end else begin
            res_status_nxt = ST_DUP;
          end
          state_nxt = S_DONE;
        end else if (!pend_r && !issue) begin
          if (op_r == OP_FIND) begin
            res_status_nxt = ST_NOT_FOUND;
          end else if (count_r == CNT_W'(MAX_ENTRIES)) begin
            res_status_nxt = ST_FULL;
          end else begin
            name_we        = 1'b1;
            vt_we          = 1'b1;
            vt_waddr       = count_r[IDX_W-1:0];
            vt_wdata       = {val_r, typ_r};
            count_nxt      = count_r + 1'b1;
            ext_nxt        = ext_r || (typ_r == TYPE_EXTERN);
            res_status_nxt = ST_OK;
            res_idx_nxt    = count_r[IDX_W-1:0];
            res_ext_nxt    = ext_r || (typ_r == TYPE_EXTERN);
          end
          state_nxt = S_DONE;
        end else begin
          pend_nxt = issue;
          if (issue) begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end

      S_RELOC: begin
        issue = (scan_r < count_r);
        // write back the entry read last cycle if it is data
        if (pend_r && vt_rd[TYPE_W-1:0] == TYPE_DATA) begin
          vt_we = 1'b1;
        end
        if (!pend_r && !issue) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          pend_nxt = issue;
          if (issue) begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_word.ready) begin
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_val_nxt    = res_val_r;
          out_typ_nxt    = res_typ_r;
          out_ext_nxt    = res_ext_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ext_r       <= 1'b0;
      code_base_r <= CODE_BASE_RST;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ext_r       <= ext_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        code_base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    name_r       <= name_nxt;
    too_long_r   <= too_long_nxt;
    val_r        <= val_nxt;
    typ_r        <= typ_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_val_r    <= res_val_nxt;
    res_typ_r    <= res_typ_nxt;
    res_ext_r    <= res_ext_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_val_r    <= out_val_nxt;
    out_typ_r    <= out_typ_nxt;
    out_ext_r    <= out_ext_nxt;
  end

  // entry_index carries the low bits of the table index
  assign out_idx_wide = {{ENTRY_INDEX_W{1'b0}}, out_idx_r};

  assign out_word.valid        = out_valid_r;
  assign out_word.status       = out_status_r;
  assign out_word.entry_index  = out_idx_wide[ENTRY_INDEX_W-1:0];
  assign out_word.found_value  = out_val_r;
  assign out_word.found_type   = out_typ_r;
  assign out_word.any_external = out_ext_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    name_we |-> (count_r < CNT_W'(MAX_ENTRIES)) && vt_we)
    else $error("name written into a full table");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1))
    else $error("entry count moved by more than one");

  a_ext_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(ext_r))
    else $error("external flag cleared outside reset");
`endif

endmodule

// ===== sim/symbol_table_engine_core_tb.sv =====
// Testbench for symbol_table_engine_core: directed and random define/add/find/relocate words.
// Results are predicted in a scoreboard class and checked in order of arrival.
// Depends on ste_pkg, ste_if and the RTL of symbol_table_engine_core.
`timescale 1ns / 1ps

module symbol_table_engine_core_tb;
  import ste_pkg::*;

  localparam int MAX_ENTRIES  = 64;
  localparam int NAME_BYTES   = 32;
  localparam int CYCLE_LIMIT  = 600000;  // the run is near 1100 words
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 400;     // long output stall, fills the block
  localparam int TAIL_CYCLES  = 80;
  localparam int PHASE_WORDS  = 260;
  localparam string LABEL_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  // One input word; the name is the four name_bytes words, byte 0 in bits 7:0.
  typedef struct {
    op_t                   op;
    logic [255:0]          name;
    logic [VALUE_W-1:0]    value;
    logic [TYPE_W-1:0]     stype;
  } word_t;

  // One output word.
  typedef struct {
    status_t               status;
    logic [ENTRY_INDEX_W-1:0] idx;
    logic [VALUE_W-1:0]    fval;
    logic [TYPE_W-1:0]     ftype;
    logic                  ext;
  } result_t;

  // Symbol table shadow: predicts each accepted word, checks replies in order.
  class symbol_table_checker;
    logic [255:0]       names[MAX_ENTRIES];
    logic [VALUE_W-1:0] vals[MAX_ENTRIES];
    logic [TYPE_W-1:0]  types[MAX_ENTRIES];
    int                 count;
    logic [VALUE_W-1:0] code_base;
    result_t            pending_replies[$];
    int                 errors;
    int                 n_checked;

    function new();
      count     = 0;
      code_base = CODE_BASE_RST;
      errors    = 0;
      n_checked = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    // Cut at first NUL or stop char, clear everything after; returns length.
    function int cut_name(inout logic [255:0] w, input logic [7:0] stop);
      int len;
      len = NAME_BYTES;
      for (int i = 0; i < NAME_BYTES; i++)
        if (w[8*i +: 8] == CHAR_NUL || w[8*i +: 8] == stop) begin
          len = i;
          break;
        end
      for (int i = 0; i < NAME_BYTES; i++)
        if (i >= len) w[8*i +: 8] = CHAR_NUL;
      return len;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LOW_A && c <= CHAR_LOW_Z);
    endfunction

    // Names of full length (no NUL) never match.
    function int locate(logic [255:0] w, int len);
      if (len > NAME_BYTES - 1) return -1;
      for (int i = 0; i < count; i++)
        if (names[i] === w) return i;
      return -1;
    endfunction

    // Duplicate wins over full table; stored name keeps NAME_BYTES-1 chars.
    function status_t insert(logic [255:0] w, logic [VALUE_W-1:0] v,
                             logic [TYPE_W-1:0] t, output logic [ENTRY_INDEX_W-1:0] idx);
      int len;
      idx = '0;
      len = cut_name(w, CHAR_NUL);
      if (locate(w, len) >= 0) return ST_DUP;
      if (count >= MAX_ENTRIES) return ST_FULL;
      w[255:248] = CHAR_NUL;
      names[count] = w;
      vals[count]  = v;
      types[count] = t;
      idx = ENTRY_INDEX_W'(count);
      count++;
      return ST_OK;
    endfunction

    function void note_word(word_t wd);
      result_t            r;
      logic [255:0]       w;
      logic [7:0]         c;
      logic [VALUE_W-1:0] shift;
      int                 len;
      int                 hit;
      bit                 ok;
      r.status = ST_OK;
      r.idx    = '0;
      r.fval   = '0;
      r.ftype  = '0;
      r.ext    = 1'b0;
      w = wd.name;
      case (wd.op)
        OP_DEFINE: begin
          len = cut_name(w, CHAR_COLON);
          ok  = len > 0 && len < NAME_BYTES && is_letter(w[7:0]);
          for (int i = 1; i < NAME_BYTES; i++) begin
            c = w[8*i +: 8];
            if (i < len && !(is_letter(c) || (c >= CHAR_0 && c <= CHAR_9) || c == CHAR_UNDER))
              ok = 1'b0;
          end
          if (!ok) r.status = ST_BAD_LABEL;
          else r.status = insert(w, wd.value, (wd.stype != TYPE_CODE) ? TYPE_DATA : TYPE_CODE,
                                 r.idx);
        end
        OP_ADD: r.status = insert(w, wd.value, wd.stype, r.idx);
        OP_FIND: begin
          len = cut_name(w, CHAR_NUL);
          hit = locate(w, len);
          if (hit < 0) r.status = ST_NOT_FOUND;
          else begin
            r.idx   = ENTRY_INDEX_W'(hit);
            r.fval  = vals[hit];
            r.ftype = types[hit];
          end
        end
        default: begin
          // relocate: data entries only, 16-bit wrap
          shift = code_base + wd.value;
          for (int i = 0; i < count; i++)
            if (types[i] == TYPE_DATA) vals[i] = vals[i] + shift;
        end
      endcase
      for (int i = 0; i < count; i++)
        if (types[i] == TYPE_EXTERN) r.ext = 1'b1;
      pending_replies.push_back(r);
    endfunction

    task check_result(input result_t got);
      result_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply with status %0d and nothing pending", got.status));
        return;
      end
      want = pending_replies.pop_front();
      n_checked++;
      if (got.status !== want.status)
        report($sformatf("reply %0d status %0d, want %0d", n_checked, got.status, want.status));
      if (got.idx !== want.idx)
        report($sformatf("reply %0d entry_index %0d, want %0d", n_checked, got.idx, want.idx));
      if (got.fval !== want.fval)
        report($sformatf("reply %0d found_value %h, want %h", n_checked, got.fval, want.fval));
      if (got.ftype !== want.ftype)
        report($sformatf("reply %0d found_type %0d, want %0d", n_checked, got.ftype,
                         want.ftype));
      if (got.ext !== want.ext)
        report($sformatf("reply %0d any_external %b, want %b", n_checked, got.ext, want.ext));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [VALUE_W-1:0] cfg_wdata;

  ste_in_if  in_w ();
  ste_out_if out_w ();

  symbol_table_engine_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_w),
    .out_word  (out_w)
  );

  symbol_table_checker sb;
  bit calm;              // no idling on either side while set
  int hold_asked;        // bumped by the stimulus to request one long output stall
  int hold_served;
  int hold_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: sample the pre-edge handshake, then pick ready for the next cycle.
  // A hold request drops ready for HOLD_CYCLES so the block backs up into its input.
  always @(posedge clk) begin : result_side
    result_t got;
    if (rst_n && out_w.valid && out_w.ready) begin
      got.status = out_w.status;
      got.idx    = out_w.entry_index;
      got.fval   = out_w.found_value;
      got.ftype  = out_w.found_type;
      got.ext    = out_w.any_external;
      sb.check_result(got);
    end
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_w.ready <= 1'b0;
    end else begin
      out_w.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---- name builders -------------------------------------------------------

  function automatic logic [255:0] text(input string s);
    logic [255:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < NAME_BYTES; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  // Random bytes from position 'from' on (junk behind a terminator).
  function automatic logic [255:0] add_tail(input logic [255:0] w, input int from);
    for (int i = 0; i < NAME_BYTES; i++)
      if (i >= from) w[8*i +: 8] = 8'($urandom);
    return w;
  endfunction

  function automatic logic [255:0] rand_bytes();
    logic [255:0] w;
    for (int i = 0; i < 8; i++) w[32*i +: 32] = $urandom;
    return w;
  endfunction

  // Mostly short names, so collisions happen; now and then the longest ones.
  function automatic int rand_len();
    return ($urandom_range(9) == 0) ? $urandom_range(9, NAME_BYTES - 1) : $urandom_range(1, 8);
  endfunction

  function automatic logic [255:0] rand_label(input int len);
    logic [255:0] w;
    w = '0;
    w[7:0] = LABEL_CHARS[$urandom_range(51)];
    for (int i = 1; i < len; i++) w[8*i +: 8] = LABEL_CHARS[$urandom_range(62)];
    return w;
  endfunction

  function automatic int name_len(input logic [255:0] w);
    for (int i = 0; i < NAME_BYTES; i++)
      if (w[8*i +: 8] == CHAR_NUL) return i;
    return NAME_BYTES;
  endfunction

  function automatic word_t mk(input op_t op, input logic [255:0] name,
                               input logic [VALUE_W-1:0] value, input logic [TYPE_W-1:0] stype);
    word_t w;
    w.op    = op;
    w.name  = name;
    w.value = value;
    w.stype = stype;
    return w;
  endfunction

  // ---- drivers -------------------------------------------------------------

  // Random sender gaps; every so often a long one so the next word lands
  // at a different point of the block's scan.
  task automatic idle_gap();
    int n;
    n = 0;
    if (calm) return;
    while ($urandom_range(99) < IDLE_PCT) n++;
    if ($urandom_range(15) == 0) n += $urandom_range(1, 70);
    if (n > 0) begin
      in_w.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one word and wait for it to be taken; valid stays high afterwards
  // so a back-to-back word needs no extra edge.
  task automatic send_word(input word_t w);
    idle_gap();
    in_w.valid        <= 1'b1;
    in_w.opcode       <= w.op;
    in_w.name_bytes_0 <= w.name[63:0];
    in_w.name_bytes_1 <= w.name[127:64];
    in_w.name_bytes_2 <= w.name[191:128];
    in_w.name_bytes_3 <= w.name[255:192];
    in_w.value        <= w.value;
    in_w.symbol_type  <= w.stype;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    sb.note_word(w);
  endtask

  // Stop offering and wait until every reply is back.
  task automatic drain();
    in_w.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_code_base(input logic [VALUE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.code_base = v;
  endtask

  task automatic run_directed();
    // lookups on an empty table, then labels that pass and fail the syntax check
    send_word(mk(OP_FIND,   text("alpha"), 16'h0000, TYPE_CODE));
    send_word(mk(OP_RELOC,  '0, 16'h0000, TYPE_CODE));
    send_word(mk(OP_DEFINE, add_tail(text("alpha:"), 6), 16'h0000, TYPE_CODE));
    send_word(mk(OP_DEFINE, text("Beta_9"), 16'hFFFF, TYPE_DATA));
    send_word(mk(OP_DEFINE, text("zeta"), 16'h0010, 2'd3));        // nonzero type -> data
    send_word(mk(OP_DEFINE, '0, 16'h0001, TYPE_CODE));             // empty
    send_word(mk(OP_DEFINE, add_tail(text(":x"), 2), 16'h0001, TYPE_CODE));
    send_word(mk(OP_DEFINE, text("9lives"), 16'h0001, TYPE_CODE));
    send_word(mk(OP_DEFINE, text("ab-c"), 16'h0001, TYPE_CODE));
    send_word(mk(OP_DEFINE, text("a") | (256'h80 << 8), 16'h0001, TYPE_CODE));
    send_word(mk(OP_DEFINE, (text("b") << 8) | 256'hC1, 16'h0001, TYPE_CODE));
    send_word(mk(OP_DEFINE, text("abcdefghijklmnopqrstuvwxyzABCDE"), 16'h0042, TYPE_CODE));
    send_word(mk(OP_DEFINE, text("Abcdefghijklmnopqrstuvwxyz012345"), 16'h0042, TYPE_CODE));
    // unterminated name: stored truncated, never found as given
    send_word(mk(OP_ADD,    {32{8'hFF}}, 16'h8000, TYPE_EXTERN));
    send_word(mk(OP_FIND,   {32{8'hFF}}, 16'h0000, TYPE_CODE));
    send_word(mk(OP_FIND,   {8'h00, {31{8'hFF}}}, 16'h0000, TYPE_CODE));
    // duplicates by add and by define
    send_word(mk(OP_ADD,    text("alpha"), 16'h0005, TYPE_CODE));
    send_word(mk(OP_DEFINE, text("alpha:"), 16'h0005, TYPE_DATA));
    // type 3 kept as given; an empty name is fine for a plain add
    send_word(mk(OP_ADD,    text("odd"), 16'h1234, 2'd3));
    send_word(mk(OP_FIND,   text("odd"), 16'h0000, TYPE_CODE));
    send_word(mk(OP_ADD,    '0, 16'h7777, TYPE_DATA));
    send_word(mk(OP_FIND,   '0, 16'h0000, TYPE_CODE));
    // relocate with wrap, then read a data entry back
    send_word(mk(OP_RELOC,  '0, 16'hFFFF, TYPE_CODE));
    send_word(mk(OP_FIND,   text("Beta_9"), 16'h0000, TYPE_CODE));
    send_word(mk(OP_FIND,   add_tail(text("alpha"), 6), 16'h0000, TYPE_CODE));
  endtask

  // Mostly meaningful traffic: finds of stored names, duplicates, new labels,
  // relocates; the rest is broken labels and raw noise. The table fills
  // part way through the run, after which adds report full.
  task automatic run_random(input int n_words);
    word_t        w;
    logic [255:0] nm;
    int           pick;
    int           len;
    int           k;
    for (int j = 0; j < n_words; j++) begin
      pick = $urandom_range(99);
      if ($urandom_range(7) == 0) w.value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else w.value = 16'($urandom);
      w.stype = 2'($urandom_range(3));
      if (pick < 7) begin
        // new label, sometimes with a colon and junk after it
        nm  = rand_label(rand_len());
        len = name_len(nm);
        if ($urandom_range(1) && len < NAME_BYTES) begin
          nm[8*len +: 8] = CHAR_COLON;
          nm = add_tail(nm, len + 1);
        end
        w.op = OP_DEFINE;
      end else if (pick < 11) begin
        nm   = ($urandom_range(3) == 0) ? rand_bytes() : rand_label(rand_len());
        w.op = OP_ADD;
      end else if (pick < 18 && sb.count > 0) begin
        // duplicate of a stored name
        nm  = sb.names[$urandom_range(sb.count - 1)];
        len = name_len(nm);
        if ($urandom_range(1)) begin
          nm[8*len +: 8] = CHAR_COLON;
          nm   = add_tail(nm, len + 1);
          w.op = OP_DEFINE;
        end else begin
          nm   = add_tail(nm, len + 1);
          w.op = OP_ADD;
        end
      end else if (pick < 55 && sb.count > 0) begin
        nm  = sb.names[$urandom_range(sb.count - 1)];
        len = name_len(nm);
        if ($urandom_range(1)) nm = add_tail(nm, len + 1);
        w.op = OP_FIND;
      end else if (pick < 65) begin
        nm   = rand_label(rand_len());
        w.op = OP_FIND;
      end else if (pick < 76) begin
        nm   = rand_bytes();
        w.op = OP_RELOC;
      end else if (pick < 90) begin
        // label that should fail the syntax check
        nm  = rand_label(rand_len());
        len = name_len(nm);
        k   = $urandom_range(len - 1);
        case ($urandom_range(4))
          0: nm[7:0] = CHAR_0 + 8'($urandom_range(9));
          1: nm[8*k +: 8] = 8'($urandom_range(1, 255));
          2: nm = add_tail(256'(CHAR_COLON), 1);
          3: nm = rand_label(NAME_BYTES);
          default: nm[8*k +: 8] = 8'($urandom_range(128, 255));
        endcase
        w.op = OP_DEFINE;
      end else begin
        nm   = rand_bytes();
        w.op = op_t'($urandom_range(3));
      end
      w.name = nm;
      send_word(w);
    end
  endtask

  // ---- sequence ------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_w.valid        = 1'b0;
    in_w.opcode       = OP_FIND;
    in_w.name_bytes_0 = '0;
    in_w.name_bytes_1 = '0;
    in_w.name_bytes_2 = '0;
    in_w.name_bytes_3 = '0;
    in_w.value        = '0;
    in_w.symbol_type  = '0;
    out_w.ready       = 1'b0;
    calm              = 1'b0;
    hold_asked        = 0;
    hold_served       = 0;
    hold_left         = 0;
    sb = new();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // code_base at its reset value
    run_directed();
    drain();

    // long output stall at the start of this phase
    write_code_base(16'h0000);
    hold_asked++;
    run_random(PHASE_WORDS);
    drain();

    // no idling on either side
    write_code_base(16'hFFFF);
    calm = 1'b1;
    run_random(PHASE_WORDS);
    drain();
    calm = 1'b0;

    write_code_base(16'($urandom_range(65535)));
    run_random(PHASE_WORDS);
    drain();

    write_code_base(16'h0001);
    run_random(PHASE_WORDS);
    drain();

    // catch any stray reply
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d replies never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ste_pkg.sv
rtl/ste_if.sv
rtl/ste_ram.sv
rtl/ste_name_prep.sv
rtl/symbol_table_engine_core.sv
sim/symbol_table_engine_core_tb.sv
